// ===== hw/rtl/cci_pkg.sv =====
// shared types, codes and reset constants of the coil current interpolator
package cci_pkg;

   typedef struct packed {
      logic [15:0] energy;
      logic [15:0] top;
      logic [15:0] bottom;
   } point_type;

   typedef enum logic [0:0] {
      CMD_LOAD    = 1'b0,
      CMD_COMPUTE = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_CAL_FIELD     = 1'b0,
      CSR_CURRENT_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_TOP_RANGE    = 2'd1,
      STATUS_BOTTOM_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LERP_MUL,
      ST_LERP_DIV,
      ST_LERP_WAIT,
      ST_SCALE_MUL,
      ST_LIMIT_MUL,
      ST_SCALE_CHECK,
      ST_SCALE_WAIT
   } eng_state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] top;
      logic [15:0] bottom;
      status_type  status;
   } result_type;

   localparam logic [15:0] CAL_FIELD_RESET     = 16'd24576;
   localparam logic [15:0] CURRENT_LIMIT_RESET = 16'd61440;
   localparam int          DIV_STEPS           = 16;

   // default calibration points, the last one repeats for extra entries
   function automatic point_type default_point(input int unsigned k);
      point_type p;
      case (k)
         0:       p = '{energy: 16'd589,  top: 16'd6144, bottom: 16'd2560};
         1:       p = '{energy: 16'd922,  top: 16'd7168, bottom: 16'd3584};
         2:       p = '{energy: 16'd1280, top: 16'd7168, bottom: 16'd3584};
         3:       p = '{energy: 16'd2048, top: 16'd8192, bottom: 16'd4096};
         default: p = '{energy: 16'd3584, top: 16'd9216, bottom: 16'd4608};
      endcase
      return p;
   endfunction

endpackage

// ===== hw/rtl/cci_point_table.sv =====
// calibration point registers with one write port and one indexed read port
module cci_point_table #(
   parameter int TABLE_POINTS = 5,
   parameter int IDX_W        = $clog2(TABLE_POINTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  cci_pkg::point_type   wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output cci_pkg::point_type   rd_data,
   output cci_pkg::point_type   first_point,
   output cci_pkg::point_type   last_point
);
   import cci_pkg::*;

   point_type entry_ff [TABLE_POINTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TABLE_POINTS; k++) begin
            entry_ff[k] <= default_point(k);
         end
      end else if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data     = entry_ff[rd_addr];
   assign first_point = entry_ff[0];
   assign last_point  = entry_ff[TABLE_POINTS-1];

endmodule

// ===== hw/rtl/cci_serial_div.sv =====
// restoring divider, one quotient bit per cycle, quotient known to fit 16 bits
module cci_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cci_pkg::div_req_type  div_req,
   output cci_pkg::div_rsp_type  div_rsp
);
   import cci_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      quo_ff, quo_in;
   logic [15:0]      divisor_ff, divisor_in;
   logic [16:0]      trial;
   logic [16:0]      diff;
   logic             ge;

   always_comb begin
      trial      = {rem_ff, quo_ff[15]};
      diff       = trial - {1'b0, divisor_ff};
      ge         = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         // upper half is below the divisor, so 16 steps give the quotient
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = div_req.dividend[31:16];
         quo_in     = div_req.dividend[15:0];
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[15:0] : trial[15:0];
         quo_in   = {quo_ff[14:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/cci_engine.sv =====
// sequencer with the shared multiplier: segment scan, interpolation, scaling, range check
module cci_engine #(
   parameter int TABLE_POINTS = 5,
   parameter int IDX_W        = $clog2(TABLE_POINTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start_compute,
   input  logic signed [15:0]    field_value,
   input  logic [15:0]           energy_value,
   input  logic [15:0]           cal_field,
   input  logic [15:0]           current_limit,
   input  cci_pkg::point_type    first_point,
   input  cci_pkg::point_type    last_point,
   input  cci_pkg::point_type    rd_data,
   output logic [IDX_W-1:0]      rd_addr,
   output cci_pkg::div_req_type  div_req,
   input  cci_pkg::div_rsp_type  div_rsp,
   output logic                  busy,
   output cci_pkg::result_type   result
);
   import cci_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

   eng_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   point_type          lo_ff, lo_in;
   point_type          hi_ff, hi_in;
   logic [15:0]        energy_ff, energy_in;
   logic signed [15:0] field_ff, field_in;
   logic [15:0]        x_ff, x_in;
   logic [15:0]        span_ff, span_in;
   logic               ch_ff, ch_in;
   logic               neg_ff, neg_in;
   logic [15:0]        top_ff, top_in;
   logic [15:0]        bot_ff, bot_in;
   logic signed [33:0] mul_ff, mul_in;
   logic signed [33:0] p_ff, p_in;
   result_type         result_ff, result_in;

   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] mul_mag;
   logic [15:0]        lo_cur, hi_cur, step, lerp_val;
   logic               in_segment;
   logic               out_of_range;

   always_comb begin
      lo_cur       = ch_ff ? lo_ff.bottom : lo_ff.top;
      hi_cur       = ch_ff ? hi_ff.bottom : hi_ff.top;
      mul_mag      = mul_ff[33] ? -mul_ff : mul_ff;
      step         = neg_ff ? 16'(~div_rsp.quotient + 16'd1) : div_rsp.quotient;
      lerp_val     = lo_cur + step;
      in_segment   = (energy_ff >= lo_ff.energy) && (energy_ff < rd_data.energy);
      out_of_range = p_ff[33] || (p_ff >= mul_ff);
      mul_in       = mul_a * mul_b;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_compute) begin
               if (energy_value <= first_point.energy ||
                   energy_value >= last_point.energy) begin
                  state_in = ST_SCALE_MUL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (in_segment) begin
               state_in = ST_LERP_MUL;
            end else if (ptr_ff == LAST_IDX) begin
               state_in = ST_SCALE_MUL;
            end
         end
         ST_LERP_MUL:  state_in = ST_LERP_DIV;
         ST_LERP_DIV:  state_in = ST_LERP_WAIT;
         ST_LERP_WAIT: begin
            if (div_rsp.done) begin
               state_in = ch_ff ? ST_SCALE_MUL : ST_LERP_MUL;
            end
         end
         ST_SCALE_MUL: state_in = ST_LIMIT_MUL;
         ST_LIMIT_MUL: state_in = ST_SCALE_CHECK;
         ST_SCALE_CHECK: begin
            state_in = out_of_range ? ST_IDLE : ST_SCALE_WAIT;
         end
         ST_SCALE_WAIT: begin
            if (div_rsp.done) begin
               state_in = ch_ff ? ST_IDLE : ST_SCALE_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs to the table, divider and multiplier
   always_comb begin
      busy             = state_ff != ST_IDLE;
      rd_addr          = ptr_ff;
      div_req.start    = 1'b0;
      div_req.dividend = mul_mag[31:0];
      div_req.divisor  = span_ff;
      mul_a            = '0;
      mul_b            = '0;
      unique case (state_ff)
         ST_LERP_MUL: begin
            mul_a = $signed({1'b0, hi_cur}) - $signed({1'b0, lo_cur});
            mul_b = $signed({1'b0, x_ff});
         end
         ST_LERP_DIV: begin
            div_req.start = 1'b1;
         end
         ST_SCALE_MUL: begin
            mul_a = $signed({1'b0, (ch_ff ? bot_ff : top_ff)});
            mul_b = {field_ff[15], field_ff};
         end
         ST_LIMIT_MUL: begin
            mul_a = $signed({1'b0, current_limit});
            mul_b = $signed({1'b0, cal_field});
         end
         ST_SCALE_CHECK: begin
            div_req.start    = !out_of_range;
            div_req.dividend = p_ff[31:0];
            div_req.divisor  = cal_field;
         end
         default: begin
         end
      endcase
   end

   // working registers
   always_comb begin
      ptr_in    = ptr_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      energy_in = energy_ff;
      field_in  = field_ff;
      x_in      = x_ff;
      span_in   = span_ff;
      ch_in     = ch_ff;
      neg_in    = neg_ff;
      top_in    = top_ff;
      bot_in    = bot_ff;
      p_in      = p_ff;
      result_in = '{valid: 1'b0, top: result_ff.top, bottom: result_ff.bottom,
                    status: result_ff.status};
      case (state_ff)
         ST_IDLE: begin
            energy_in = energy_value;
            field_in  = field_value;
            ch_in     = 1'b0;
            ptr_in    = IDX_W'(1);
            lo_in     = first_point;
            if (energy_value <= first_point.energy) begin
               top_in = first_point.top;
               bot_in = first_point.bottom;
            end else begin
               top_in = last_point.top;
               bot_in = last_point.bottom;
            end
         end
         ST_SCAN: begin
            if (in_segment) begin
               hi_in   = rd_data;
               x_in    = energy_ff - lo_ff.energy;
               span_in = rd_data.energy - lo_ff.energy;
            end else if (ptr_ff == LAST_IDX) begin
               // no segment matched in an unordered table
               top_in = rd_data.top;
               bot_in = rd_data.bottom;
            end else begin
               lo_in  = rd_data;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_LERP_DIV: begin
            neg_in = mul_ff[33];
         end
         ST_LERP_WAIT: begin
            if (div_rsp.done) begin
               if (ch_ff) begin
                  bot_in = lerp_val;
               end else begin
                  top_in = lerp_val;
               end
               ch_in = !ch_ff;
            end
         end
         ST_LIMIT_MUL: begin
            p_in = mul_ff;
         end
         ST_SCALE_CHECK: begin
            if (out_of_range) begin
               result_in = '{valid: 1'b1, top: 16'd0, bottom: 16'd0,
                             status: (ch_ff ? STATUS_BOTTOM_RANGE : STATUS_TOP_RANGE)};
            end
         end
         ST_SCALE_WAIT: begin
            if (div_rsp.done) begin
               if (ch_ff) begin
                  result_in = '{valid: 1'b1, top: top_ff, bottom: div_rsp.quotient,
                                status: STATUS_OK};
               end else begin
                  top_in = div_rsp.quotient;
                  ch_in  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         result_ff <= '0;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff           <= ptr_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      energy_ff        <= energy_in;
      field_ff         <= field_in;
      x_ff             <= x_in;
      span_ff          <= span_in;
      ch_ff            <= ch_in;
      neg_ff           <= neg_in;
      top_ff           <= top_in;
      bot_ff           <= bot_in;
      mul_ff           <= mul_in;
      p_ff             <= p_in;
   end

   assign result = result_ff;

endmodule

// ===== hw/rtl/coil_current_interpolator_unit.sv =====
// Coil current interpolator top level: command port, register port, table, engine, divider
//
// A load beat (cmd 0) writes one table point in the cycle it is taken and
// leaves busy low; a load to an index past the table is dropped. A compute
// beat (cmd 1) raises busy until its result is shown on the rsp_ ports for
// exactly one cycle with rsp_valid high; the receiver cannot stall, so it
// must take the beat then. Compute runs on the single 16-step serial divider,
// used for two interpolation quotients and two scaling quotients when the
// energy lies inside the table, with a short segment scan of one table point
// per cycle ahead of them, and for the two scaling quotients alone when the
// energy lies at or beyond an end of the table. An out-of-range top or bottom
// current ends the item early. The next beat may be taken at the edge that
// takes the result. Write csr_ registers only while idle.
module coil_current_interpolator_unit #(
   parameter int TABLE_POINTS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [2:0]         req_point_index,
   input  logic [15:0]        req_point_energy,
   input  logic [15:0]        req_point_top,
   input  logic [15:0]        req_point_bottom,
   input  logic signed [15:0] req_field_value,
   input  logic [15:0]        req_energy_value,
   output logic               rsp_valid,
   output logic [15:0]        rsp_top_current,
   output logic [15:0]        rsp_bottom_current,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import cci_pkg::*;

   localparam int IDX_W = $clog2(TABLE_POINTS);

   logic [15:0]       cal_field_ff, cal_field_in;
   logic [15:0]       current_limit_ff, current_limit_in;
   logic              accept;
   logic              load_en;
   logic [4:0]        load_idx;
   logic [IDX_W-1:0]  rd_addr;
   point_type         rd_data, first_point, last_point, load_point;
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   result_type        result;

   assign accept     = start && !busy;
   assign load_idx   = {2'b00, req_point_index};
   assign load_en    = accept && (req_cmd == CMD_LOAD) &&
                       (load_idx < 5'(TABLE_POINTS));
   assign load_point = '{energy: req_point_energy, top: req_point_top,
                         bottom: req_point_bottom};

   always_comb begin
      cal_field_in     = cal_field_ff;
      current_limit_in = current_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAL_FIELD:     cal_field_in     = csr_wdata;
            CSR_CURRENT_LIMIT: current_limit_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_field_ff     <= CAL_FIELD_RESET;
         current_limit_ff <= CURRENT_LIMIT_RESET;
      end else begin
         cal_field_ff     <= cal_field_in;
         current_limit_ff <= current_limit_in;
      end
   end

   cci_point_table #(
      .TABLE_POINTS (TABLE_POINTS),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (load_en),
      .wr_addr     (load_idx[IDX_W-1:0]),
      .wr_data     (load_point),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .first_point (first_point),
      .last_point  (last_point)
   );

   cci_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   cci_engine #(
      .TABLE_POINTS (TABLE_POINTS),
      .IDX_W        (IDX_W)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start_compute (accept && (req_cmd == CMD_COMPUTE)),
      .field_value   (req_field_value),
      .energy_value  (req_energy_value),
      .cal_field     (cal_field_ff),
      .current_limit (current_limit_ff),
      .first_point   (first_point),
      .last_point    (last_point),
      .rd_data       (rd_data),
      .rd_addr       (rd_addr),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .busy          (busy),
      .result        (result)
   );

   assign rsp_valid          = result.valid;
   assign rsp_top_current    = result.top;
   assign rsp_bottom_current = result.bottom;
   assign rsp_status         = result.status;

   // a compute beat always occupies the engine
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_COMPUTE) |=> busy)
      else $error("compute beat did not raise busy");

   // a result only closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in progress");

   // failed checks carry zero currents
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_top_current == 16'd0 && rsp_bottom_current == 16'd0))
      else $error("nonzero current with range failure");

   // the divider never runs on an idle engine
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> busy)
      else $error("divider started while idle");

endmodule
